### design/sumd_pkg.sv
package sumd_pkg;

    localparam int unsigned BUFFER_BYTES  = 14;
    localparam int unsigned MAILBOX_COUNT = 8;
    localparam int unsigned TABLE_BITS    = 40;
    localparam int unsigned SIZE_BITS     = 5;

    localparam logic [7:0] HDR_FLAG     = 8'h80;
    localparam logic [7:0] MBOX_MASK    = 8'h70;
    localparam logic [7:0] LEN_MASK     = 8'h0F;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;
    localparam logic [3:0] LEN_CODE_LIM = 4'd13;   // length code 13 means 14 bytes: too long

    // Controller to datapath
    typedef struct packed {
        logic hdr_load;     // accepted header: latch mailbox/length, clear buffer
        logic pkt_take;     // accepted data packet: pack bits, fold into XOR
        logic emit_start;   // good checksum: arm the drain
        logic emit_step;    // move the next decoded byte into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic byte_hi;      // bit 7 of the incoming byte
        logic hdr_ok;       // header with an accepted length
        logic pkt_last;     // this packet completes the message
        logic csum_emit;    // checksum matches and at least one byte to deliver
        logic emit_last;    // byte being moved out is the last one
        logic out_free;     // output register can take a byte this cycle
    } t_status;

    // Packet count for a message: ceil(8*len/7), len = code + 1
    function automatic logic [3:0] f_packets(input logic [3:0] code);
        logic [3:0] n;
        case (code)
            4'd0:    n = 4'd2;
            4'd1:    n = 4'd3;
            4'd2:    n = 4'd4;
            4'd3:    n = 4'd5;
            4'd4:    n = 4'd6;
            4'd5:    n = 4'd7;
            4'd6:    n = 4'd8;
            4'd7:    n = 4'd10;
            4'd8:    n = 4'd11;
            4'd9:    n = 4'd12;
            4'd10:   n = 4'd13;
            4'd11:   n = 4'd14;
            4'd12:   n = 4'd15;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // p mod 7 for a 4-bit packet count
    function automatic logic [2:0] f_mod7(input logic [3:0] p);
        logic [3:0] m;
        if (p < 4'd7) begin
            m = p;
        end else if (p < 4'd14) begin
            m = p - 4'd7;
        end else begin
            m = p - 4'd14;
        end
        return m[2:0];
    endfunction

    // p div 7 for a 4-bit packet count
    function automatic logic [1:0] f_div7(input logic [3:0] p);
        logic [1:0] q;
        if (p < 4'd7) begin
            q = 2'd0;
        end else if (p < 4'd14) begin
            q = 2'd1;
        end else begin
            q = 2'd2;
        end
        return q;
    endfunction

endpackage

### design/sumd_ctrl.sv
module sumd_ctrl
    import sumd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_HUNT = 4'b0001,
        S_DATA = 4'b0010,
        S_CSUM = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign o_rx_ready = (r_state != S_EMIT);
    assign w_take     = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (w_take && i_status.hdr_ok) begin
                    o_cmd.hdr_load = 1'b1;
                    n_state        = S_DATA;
                end
            end
            S_DATA: begin
                if (w_take) begin
                    if (i_status.byte_hi) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.pkt_take = 1'b1;
                        if (i_status.pkt_last) begin
                            n_state = S_CSUM;
                        end
                    end
                end
            end
            S_CSUM: begin
                if (w_take) begin
                    if (i_status.csum_emit) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/sumd_datapath.sv
module sumd_datapath
    import sumd_pkg::*;
#(
    parameter int unsigned MAX_MSG_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TABLE_BITS-1:0] i_cfg_data,
    input  logic [7:0]            i_rx_byte,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_mailbox_select,
    output logic [3:0]            o_byte_index,
    output logic [7:0]            o_data_byte,
    output logic                  o_last_byte
);

    localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(MAX_MSG_BYTES);

    logic [TABLE_BITS-1:0] r_table;
    logic [2:0]            r_mbox;
    logic [3:0]            r_len;
    logic [3:0]            r_pkt_exp;
    logic [3:0]            r_pkt_seen;
    logic [6:0]            r_xor;
    logic [7:0]            r_buf [BUFFER_BYTES];
    logic [3:0]            r_emit_idx;
    logic [3:0]            r_emit_cnt;
    logic                  r_out_valid;
    logic [2:0]            r_out_mbox;
    logic [3:0]            r_out_idx;
    logic [7:0]            r_out_data;
    logic                  r_out_last;

    logic [3:0]           w_len_code;
    logic [4:0]           w_seen_inc;
    logic [2:0]           w_r;
    logic [1:0]           w_q;
    logic [2:0]           w_rsh;
    logic [7:0]           w_newb;
    logic [7:0]           w_remb;
    logic [3:0]           w_idx_new;
    logic [3:0]           w_idx_rem;
    logic                 w_rem_en;
    logic [5:0]           w_base;
    logic [SIZE_BITS-1:0] w_sz_raw;
    logic [SIZE_BITS-1:0] w_sz;
    logic [3:0]           w_n;
    logic                 w_csum_ok;

    assign w_len_code = i_rx_byte[3:0];

    // Packing: packet p lands with its low bits shifted into byte p - p/7,
    // the bits that spill over go to the low end of the byte before.
    assign w_r       = f_mod7(r_pkt_seen);
    assign w_q       = f_div7(r_pkt_seen);
    assign w_rsh     = 3'd7 - w_r;
    assign w_newb    = 8'(((i_rx_byte & (PAYLOAD_MASK >> w_r)) << (4'd1 + 4'(w_r))) & BYTE_MASK);
    assign w_remb    = (i_rx_byte & (PAYLOAD_MASK & (BYTE_MASK << w_rsh))) >> w_rsh;
    assign w_idx_new = r_pkt_seen - 4'(w_q);
    assign w_idx_rem = r_pkt_seen - 4'd1 - 4'(w_q);
    assign w_rem_en  = (w_r != 3'd0) && (r_pkt_seen != 4'd0);
    assign w_seen_inc = {1'b0, r_pkt_seen} + 5'd1;

    // Mailbox size, clamped, and delivered byte count
    assign w_base   = 6'(r_mbox) * 6'd5;
    assign w_sz_raw = r_table[w_base +: SIZE_BITS];
    assign w_sz     = (w_sz_raw > SIZE_CAP) ? SIZE_CAP : w_sz_raw;
    assign w_n      = (w_sz < {1'b0, r_len}) ? w_sz[3:0] : r_len;
    assign w_csum_ok = (i_rx_byte == {1'b0, r_xor});

    assign o_status.byte_hi   = i_rx_byte[7];
    assign o_status.hdr_ok    = ((i_rx_byte & HDR_FLAG) != 8'd0) && (w_len_code < LEN_CODE_LIM);
    assign o_status.pkt_last  = (w_seen_inc[3:0] >= r_pkt_exp);
    assign o_status.csum_emit = w_csum_ok && (w_n != 4'd0);
    assign o_status.emit_last = ((r_emit_idx + 4'd1) == r_emit_cnt);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table    <= '0;
            r_mbox     <= '0;
            r_len      <= '0;
            r_pkt_exp  <= '0;
            r_pkt_seen <= '0;
            r_xor      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table <= i_cfg_data;
            end
            if (i_cmd.hdr_load) begin
                r_mbox     <= 3'((i_rx_byte & MBOX_MASK) >> 4);
                r_len      <= w_len_code + 4'd1;
                r_pkt_exp  <= f_packets(w_len_code);
                r_pkt_seen <= '0;
                r_xor      <= '0;
            end else if (i_cmd.pkt_take) begin
                r_pkt_seen <= w_seen_inc[3:0];
                r_xor      <= r_xor ^ i_rx_byte[6:0];
            end
            if (i_cmd.emit_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Assembly buffer: cleared at a header, OR-ed into per packet
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BUFFER_BYTES; i++) begin
            if (i_cmd.hdr_load) begin
                r_buf[i] <= '0;
            end else if (i_cmd.pkt_take) begin
                r_buf[i] <= r_buf[i]
                          | ((w_idx_new == 4'(i)) ? w_newb : 8'd0)
                          | ((w_rem_en && (w_idx_rem == 4'(i))) ? w_remb : 8'd0);
            end
        end
    end

    // Drain counter and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_emit_idx <= '0;
            r_emit_cnt <= w_n;
        end else if (i_cmd.emit_step) begin
            r_emit_idx <= r_emit_idx + 4'd1;
        end
        if (i_cmd.emit_step) begin
            r_out_mbox <= r_mbox;
            r_out_idx  <= r_emit_idx;
            r_out_data <= r_buf[r_emit_idx];
            r_out_last <= o_status.emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mailbox_select = r_out_mbox;
    assign o_byte_index     = r_out_idx;
    assign o_data_byte      = r_out_data;
    assign o_last_byte      = r_out_last;

endmodule

### design/seven_bit_uart_mailbox_deframer.sv
// Seven-bit UART mailbox deframer. Feed it received UART bytes on the rx
// channel. A header byte (bit 7 set) names a mailbox (bits 6:4) and a length
// minus one (bits 3:0); lengths of 14 bytes or more are dropped. The data
// packets that follow carry 7 bits each, packed MSB first into a 14-byte
// buffer, and a checksum byte closes the message. If the checksum equals the
// XOR of the packets, min(length, mailbox size) bytes come out on the output
// channel, one request per byte, tagged with mailbox and position, the last
// one flagged. A bad checksum or a header byte in mid-message drops the
// message silently. Mailbox sizes live in one 40-bit register, 5 bits per
// mailbox (mailbox n at bits 5n+4:5n), clamped to MAX_MSG_BYTES; write it
// only while the block is idle. Received bytes are taken whenever the block is
// not draining. A good checksum starts a drain of up to 13 bytes, one per cycle
// while the single output register is free; rx ready is low until the drain
// ends. The last byte may still sit in the output register while the next
// header is taken.
module seven_bit_uart_mailbox_deframer
    import sumd_pkg::*;
#(
    parameter int unsigned MAX_MSG_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // size table write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TABLE_BITS-1:0] i_cfg_data,
    // received bytes
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_byte,
    // decoded bytes
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_mailbox_select,
    output logic [3:0]            o_byte_index,
    output logic [7:0]            o_data_byte,
    output logic                  o_last_byte
);

    t_cmd    w_cmd;
    t_status w_status;

    // Table writes are always taken
    assign o_cfg_ready = 1'b1;

    // Framing state machine: hunt, data, checksum, drain
    sumd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Size table, counters, XOR, packing buffer and output register
    sumd_datapath #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mailbox_select (o_mailbox_select),
        .o_byte_index     (o_byte_index),
        .o_data_byte      (o_data_byte),
        .o_last_byte      (o_last_byte)
    );

endmodule

### dv/tb_seven_bit_uart_mailbox_deframer.sv
module tb_seven_bit_uart_mailbox_deframer
    import sumd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_MSG_BYTES  = 16;
    localparam int          HOLD_CYCLES    = 300;   // long output hold-off in the pressure phase
    localparam int          DRAIN_CYCLES   = 20;    // quiet time after the last decoded byte
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no request moving at all

    // Where the deframer is in a message
    typedef enum logic [1:0] {
        S_HUNT,
        S_DATA,
        S_CSUM
    } t_rx_phase;

    // How a generated frame ends
    typedef enum logic [1:0] {
        FR_GOOD,     // matching checksum
        FR_BAD_SUM,  // checksum off by a non-zero 7-bit value
        FR_CUT,      // header byte in mid-data aborts the message
        FR_HDR_SUM   // checksum byte with bit 7 set, never matches
    } t_frame_kind;

    // One decoded byte as it leaves the block
    typedef struct packed {
        logic [2:0] mbox;
        logic [3:0] pos;
        logic [7:0] data;
        logic       last;
    } t_delivery;

    // Tracks the message being rebuilt from the accepted rx bytes and keeps
    // the decoded bytes that are owed on the output channel, oldest first.
    class deframe_scoreboard;
        t_rx_phase              ph = S_HUNT;
        logic [2:0]             target = '0;
        int unsigned            msg_len = 0;
        int unsigned            pkt_total = 0;
        int unsigned            pkt_seen = 0;
        logic [6:0]             run_xor = '0;
        logic [7:0]             frame_buf [BUFFER_BYTES];
        logic [TABLE_BITS-1:0]  sizes = '0;
        t_delivery              due_bytes [$];
        int                     mismatches = 0;

        function new();
            foreach (frame_buf[i]) frame_buf[i] = '0;
        endfunction

        function void stash(int unsigned at, logic [7:0] bits);
            if (at < BUFFER_BYTES) frame_buf[at] = frame_buf[at] | bits;
        endfunction

        // Accepted rx byte: advance the message and queue what it releases
        function void take_rx_byte(logic [7:0] b);
            int unsigned p;
            int unsigned r;
            int unsigned sz;
            int unsigned n;
            logic [7:0]  fresh;
            logic [7:0]  carry;
            case (ph)
                S_DATA: begin
                    if ((b & HDR_FLAG) != 0) begin
                        ph = S_HUNT;
                    end else begin
                        p = pkt_seen;
                        r = p % 7;
                        // low 7-r bits of the packet fill the current byte,
                        // the top r bits finish off the previous one
                        fresh = (b & (PAYLOAD_MASK >> r)) << (r + 1);
                        if (r != 0 && p != 0) begin
                            carry = (b & PAYLOAD_MASK & (BYTE_MASK << (7 - r))) >> (7 - r);
                            stash(p - 1 - p / 7, carry);
                        end
                        stash(p - p / 7, fresh);
                        run_xor  = run_xor ^ b[6:0];
                        pkt_seen = (p + 1) & 15;
                        if (pkt_seen >= pkt_total) ph = S_CSUM;
                    end
                end
                S_CSUM: begin
                    if (b == {1'b0, run_xor}) begin
                        sz = sizes[SIZE_BITS*target +: SIZE_BITS];
                        if (sz > MAX_MSG_BYTES) sz = MAX_MSG_BYTES;
                        n = (sz < msg_len) ? sz : msg_len;
                        for (int k = 0; k < n && k < BUFFER_BYTES; k++) begin
                            due_bytes.push_back(t_delivery'{target, 4'(k), frame_buf[k],
                                                            (k + 1 == n)});
                        end
                    end
                    ph = S_HUNT;
                end
                default: begin
                    ph = S_HUNT;
                    if ((b & HDR_FLAG) != 0 && (b & LEN_MASK) < LEN_CODE_LIM) begin
                        target    = 3'((b & MBOX_MASK) >> 4);
                        msg_len   = (b & LEN_MASK) + 1;
                        pkt_total = (msg_len * 8 + 6) / 7;
                        pkt_seen  = 0;
                        run_xor   = '0;
                        foreach (frame_buf[i]) frame_buf[i] = '0;
                        ph = S_DATA;
                    end
                end
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_result(t_delivery got);
            t_delivery want;
            if (due_bytes.size() == 0) begin
                flag($sformatf("unrequested byte: mbox %0d idx %0d data %02h last %0b",
                               got.mbox, got.pos, got.data, got.last));
                return;
            end
            want = due_bytes.pop_front();
            if (got.mbox !== want.mbox || got.pos !== want.pos ||
                got.data !== want.data || got.last !== want.last) begin
                flag($sformatf({"byte mismatch: want mbox %0d idx %0d data %02h last %0b, ",
                                "got mbox %0d idx %0d data %02h last %0b"},
                               want.mbox, want.pos, want.data, want.last,
                               got.mbox, got.pos, got.data, got.last));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TABLE_BITS-1:0] i_cfg_data = '0;
    logic                  i_rx_valid = 1'b0;
    logic                  o_rx_ready;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_mailbox_select;
    logic [3:0]            o_byte_index;
    logic [7:0]            o_data_byte;
    logic                  o_last_byte;

    deframe_scoreboard sb;

    int gap_pct = 0;      // chance per cycle that the sender sits idle
    int stall_pct = 0;    // chance per cycle that the output side stalls
    int hold_asks = 0;    // bumped by the stimulus to ask for a long hold-off
    int hold_seen = 0;    // owned by the output process
    int hold_left = 0;    // owned by the output process
    int idle_cycles = 0;

    seven_bit_uart_mailbox_deframer #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mailbox_select (o_mailbox_select),
        .o_byte_index     (o_byte_index),
        .o_data_byte      (o_data_byte),
        .o_last_byte      (o_last_byte)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output side: check each request taken at this edge, then decide ready
    // for the next one. A hold-off asked for by the stimulus is counted
    // down here so only this process ever touches the counter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(t_delivery'{o_mailbox_select, o_byte_index, o_data_byte,
                                        o_last_byte});
        end
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any request moving on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one rx byte, with random idle cycles in front of it, and hold it
    // until it is taken. Returns at the edge where the request was accepted,
    // with valid still high so back-to-back bytes need no extra edge.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.take_rx_byte(b);
    endtask

    // Header, random 7-bit packets and a closing byte chosen by kind
    task automatic send_frame(input logic [2:0] mb, input logic [3:0] code,
                              input t_frame_kind kind, output int n);
        int unsigned total;
        int unsigned cut;
        logic [6:0]  fold;
        logic [6:0]  pkt;
        total = ((code + 1) * 8 + 6) / 7;
        cut   = (kind == FR_CUT) ? $urandom_range(total - 1) : total;
        fold  = '0;
        send_byte(HDR_FLAG | {1'b0, mb, code});
        for (int i = 0; i < cut; i++) begin
            pkt  = 7'($urandom_range(127));
            fold = fold ^ pkt;
            send_byte({1'b0, pkt});
        end
        case (kind)
            FR_GOOD:    send_byte({1'b0, fold});
            FR_BAD_SUM: send_byte({1'b0, fold ^ 7'($urandom_range(1, 127))});
            default:    send_byte(HDR_FLAG | 8'($urandom_range(127)));
        endcase
        n = cut + 2;
    endtask

    // Bring the block back to header hunt, stop offering bytes and let every
    // owed byte drain, plus a little slack for the output register.
    task automatic settle();
        if (sb.ph == S_DATA) begin
            send_byte(HDR_FLAG | LEN_MASK);   // header byte aborts the message
        end else if (sb.ph == S_CSUM) begin
            send_byte(BYTE_MASK);             // can never match a checksum
        end
        i_rx_valid <= 1'b0;
        while (sb.due_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sizes(input logic [TABLE_BITS-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.sizes = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [TABLE_BITS-1:0] random_sizes();
        logic [TABLE_BITS-1:0] v;
        v = '0;
        for (int m = 0; m < MAILBOX_COUNT; m++) begin
            v[SIZE_BITS*m +: SIZE_BITS] = SIZE_BITS'($urandom_range(MAX_MSG_BYTES));
        end
        return v;
    endfunction

    // One random phase: mostly well-formed frames with random content, the
    // rest broken frames and noise. Only frame bytes count towards budget.
    task automatic run_phase(input int gap, input int stall,
                             input logic [TABLE_BITS-1:0] sizes_v,
                             input int budget, input bit squeeze);
        int         done;
        int         roll;
        int         n;
        logic [2:0] mb;
        logic [3:0] code;
        write_sizes(sizes_v);
        gap_pct   = gap;
        stall_pct = stall;
        done      = 0;
        if (squeeze) hold_asks++;
        while (done < budget) begin
            mb   = 3'($urandom_range(7));
            code = 4'($urandom_range(LEN_CODE_LIM - 1));
            roll = $urandom_range(99);
            if (squeeze && $urandom_range(9) == 0) hold_asks++;
            if (roll < 62) begin
                send_frame(mb, code, FR_GOOD, n);
            end else if (roll < 72) begin
                send_frame(mb, code, FR_BAD_SUM, n);
            end else if (roll < 82) begin
                send_frame(mb, code, FR_CUT, n);
            end else if (roll < 88) begin
                send_frame(mb, code, FR_HDR_SUM, n);
            end else begin
                n = 0;
                if (roll < 94) begin
                    send_byte(8'($urandom_range(255)));
                end else begin
                    // length of 14 bytes or more: dropped by the block
                    send_byte(HDR_FLAG | {1'b0, mb, 4'(LEN_CODE_LIM + $urandom_range(2))});
                end
            end
            done += n;
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: mailbox 0 oversized (clamped), 1 empty, 2 five bytes,
        // 7 a single byte, the rest thirteen
        write_sizes({5'd1, 5'd13, 5'd13, 5'd13, 5'd13, 5'd5, 5'd0, 5'd31});
        // data bytes while hunting are ignored
        send_byte(8'h00);
        send_byte(8'h7F);
        // too-long headers are ignored
        send_byte(8'h8D);
        send_byte(8'h8F);
        // one-byte message, all ones, good checksum
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h7F);
        send_byte(8'h00);
        // good message to an empty mailbox: nothing comes out
        send_byte(8'h90);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h26);
        // header in mid-data aborts; it is not a new header, so 7F is noise
        send_byte(8'hA3);
        send_byte(8'h55);
        send_byte(8'h80);
        send_byte(8'h7F);
        // checksum with bit 7 set never matches, then the same frame good
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);

        run_phase(0,  0,  {TABLE_BITS{1'b1}},                70, 1'b0);
        run_phase(69, 0,  TABLE_BITS'({$urandom, $urandom}), 70, 1'b0);
        run_phase(0,  69, random_sizes(),                    70, 1'b0);
        run_phase(26, 26, random_sizes(),                    70, 1'b0);
        run_phase(0,  0,  '0,                                35, 1'b0);
        // pressure: output held off while bytes keep coming, so rx backs up
        run_phase(0,  0,  random_sizes(),                    70, 1'b1);

        settle();
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
